// File: hw/rtl/drrt_pkg.sv
// Shared types, codes and defaults for the DMA region registration table.
package drrt_pkg;
	localparam int unsigned ENTRIES_DEF   = 16;
	localparam int unsigned ADDR_BITS_DEF = 48;
	localparam int unsigned LEN_BITS_DEF  = 40;
	localparam int unsigned OFS_BITS      = 40;
	localparam int unsigned ALIGN_BITS    = 5;
	localparam logic [ALIGN_BITS-1:0] ALIGN_RESET = 5'd12;
	localparam int unsigned QUEUE_DEPTH   = 2;

	typedef enum logic [1:0] {
		FUNC_REGISTER   = 2'd0,
		FUNC_UNREGISTER = 2'd1,
		FUNC_CHECK      = 2'd2,
		FUNC_UNKNOWN    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_OVERLAP   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	// Classified operation handed from front to back.
	typedef enum logic [1:0] {
		OP_DONE   = 2'd0,   // answer already known, no scan
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CHECK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_SCAN = 2'd1,
		BK_DONE = 2'd2
	} bk_state_t;
endpackage

// File: hw/rtl/drrt_front.sv
// Front end: accept a transaction, screen arguments, queue the classified operation.
module drrt_front #(
	parameter int unsigned ADDR_BITS = drrt_pkg::ADDR_BITS_DEF,
	parameter int unsigned LEN_BITS  = drrt_pkg::LEN_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      func,
	input  logic [ADDR_BITS-1:0]            address,
	input  logic [LEN_BITS-1:0]             length,
	input  logic signed [drrt_pkg::OFS_BITS-1:0] byte_offset,
	input  logic [drrt_pkg::ALIGN_BITS-1:0] align_log2,
	output logic                            q_valid,
	input  logic                            q_ready,
	output drrt_pkg::op_t                   q_op,
	output drrt_pkg::status_t               q_status,
	output logic [ADDR_BITS-1:0]            q_addr,
	output logic [LEN_BITS-1:0]             q_len
);
	localparam int unsigned QD = drrt_pkg::QUEUE_DEPTH;

	drrt_pkg::op_t     op_c;
	drrt_pkg::status_t st_c;
	logic [63:0]       amask;
	logic              aligned;

	drrt_pkg::op_t     op_q   [QD];
	drrt_pkg::status_t st_q   [QD];
	logic [ADDR_BITS-1:0] addr_q [QD];
	logic [LEN_BITS-1:0]  len_q  [QD];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;

	always_comb begin
		amask   = (64'd1 << align_log2) - 64'd1;
		aligned = ((64'(address) & amask) == 64'd0) && ((64'(length) & amask) == 64'd0)
			&& ((64'($unsigned(byte_offset)) & amask) == 64'd0);
		op_c = drrt_pkg::OP_DONE;
		st_c = drrt_pkg::ST_OK;
		unique case (drrt_pkg::func_t'(func))
			drrt_pkg::FUNC_REGISTER: begin
				if (address == '0 || length == '0) st_c = drrt_pkg::ST_INVALID;
				else op_c = drrt_pkg::OP_ADD;
			end
			drrt_pkg::FUNC_UNREGISTER: begin
				if (address == '0) st_c = drrt_pkg::ST_INVALID;
				else op_c = drrt_pkg::OP_REMOVE;
			end
			drrt_pkg::FUNC_CHECK: begin
				if (address != '0 && !byte_offset[drrt_pkg::OFS_BITS-1] && aligned)
					op_c = drrt_pkg::OP_CHECK;
			end
			default: st_c = drrt_pkg::ST_INVALID;
		endcase
	end

	assign in_ready = (cnt_q != 2'(QD));
	assign q_valid  = (cnt_q != 2'd0);
	assign q_op     = op_q[rp_q];
	assign q_status = st_q[rp_q];
	assign q_addr   = addr_q[rp_q];
	assign q_len    = len_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q[wp_q]   <= op_c;
			st_q[wp_q]   <= st_c;
			addr_q[wp_q] <= address;
			len_q[wp_q]  <= length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (q_valid && q_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end
endmodule

// File: hw/rtl/drrt_back.sv
// Back end: scan the region table one entry a cycle and produce the result.
module drrt_back #(
	parameter int unsigned ENTRIES   = drrt_pkg::ENTRIES_DEF,
	parameter int unsigned ADDR_BITS = drrt_pkg::ADDR_BITS_DEF,
	parameter int unsigned LEN_BITS  = drrt_pkg::LEN_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  drrt_pkg::op_t        q_op,
	input  drrt_pkg::status_t    q_status,
	input  logic [ADDR_BITS-1:0] q_addr,
	input  logic [LEN_BITS-1:0]  q_len,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic                 granted
);
	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned W  = ((ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS) + 1;

	drrt_pkg::bk_state_t state_q, state_d;
	logic [ENTRIES-1:0]   valid_q;
	logic [ADDR_BITS-1:0] base_q [ENTRIES];
	logic [LEN_BITS-1:0]  rlen_q [ENTRIES];
	logic [CW-1:0]        idx_q;
	logic [IW-1:0]        idx;
	drrt_pkg::op_t        op_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [LEN_BITS-1:0]  len_q;
	logic                 hit_q, free_found_q;
	logic [IW-1:0]        free_q;
	logic [2:0]           status_q;
	logic                 granted_q;
	logic                 out_valid_q;

	logic [W-1:0] a_end, b_end, a_w, b_w;
	logic         ev, ovl, contained, match, last;

	assign idx  = idx_q[IW-1:0];
	assign a_w  = W'(addr_q);
	assign b_w  = W'(base_q[idx]);
	assign a_end = a_w + W'(len_q);
	assign b_end = b_w + W'(rlen_q[idx]);
	assign ev    = valid_q[idx];
	assign ovl    = ev && (a_w < b_end) && (b_w < a_end);
	assign contained = ev && (a_w >= b_w) && (a_end <= b_end);
	assign match  = ev && (base_q[idx] == addr_q);
	assign last   = (idx_q == CW'(ENTRIES - 1));

	assign q_ready   = (state_q == drrt_pkg::BK_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign granted   = granted_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			drrt_pkg::BK_IDLE:
				if (q_valid && q_ready)
					state_d = (q_op == drrt_pkg::OP_DONE) ? drrt_pkg::BK_IDLE
						: drrt_pkg::BK_SCAN;
			drrt_pkg::BK_SCAN:
				if (last || (op_q == drrt_pkg::OP_REMOVE && match)
					|| (op_q == drrt_pkg::OP_CHECK && contained))
					state_d = drrt_pkg::BK_DONE;
			drrt_pkg::BK_DONE: state_d = drrt_pkg::BK_IDLE;
			default: state_d = drrt_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			op_q   <= q_op;
			addr_q <= q_addr;
			len_q  <= q_len;
		end
		if (state_q == drrt_pkg::BK_DONE && op_q == drrt_pkg::OP_ADD
			&& !hit_q && free_found_q) begin
			base_q[free_q] <= addr_q;
			rlen_q[free_q] <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= drrt_pkg::BK_IDLE;
			valid_q      <= '0;
			idx_q        <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			free_q       <= '0;
			status_q     <= 3'(drrt_pkg::ST_OK);
			granted_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				drrt_pkg::BK_IDLE: begin
					idx_q        <= '0;
					hit_q        <= 1'b0;
					free_found_q <= 1'b0;
					if (q_valid && q_ready && q_op == drrt_pkg::OP_DONE) begin
						status_q    <= 3'(q_status);
						granted_q   <= 1'b0;
						out_valid_q <= 1'b1;
					end
				end
				drrt_pkg::BK_SCAN: begin
					idx_q <= idx_q + CW'(1);
					case (op_q)
						drrt_pkg::OP_ADD: begin
							if (ovl) hit_q <= 1'b1;
							if (!ev && !free_found_q) begin
								free_found_q <= 1'b1;
								free_q       <= idx;
							end
						end
						drrt_pkg::OP_REMOVE:
							if (match) begin
								hit_q        <= 1'b1;
								valid_q[idx] <= 1'b0;
							end
						default: if (contained) hit_q <= 1'b1;
					endcase
				end
				drrt_pkg::BK_DONE: begin
					out_valid_q <= 1'b1;
					granted_q   <= 1'b0;
					case (op_q)
						drrt_pkg::OP_ADD: begin
							if (hit_q) status_q <= 3'(drrt_pkg::ST_OVERLAP);
							else if (!free_found_q) status_q <= 3'(drrt_pkg::ST_FULL);
							else begin
								status_q        <= 3'(drrt_pkg::ST_OK);
								valid_q[free_q] <= 1'b1;
							end
						end
						drrt_pkg::OP_REMOVE:
							status_q <= hit_q ? 3'(drrt_pkg::ST_OK)
								: 3'(drrt_pkg::ST_NOT_FOUND);
						default: begin
							status_q  <= 3'(drrt_pkg::ST_OK);
							granted_q <= hit_q;
						end
					endcase
				end
				default: ;
			endcase
		end
	end
endmodule

// File: hw/rtl/dma_region_registration_table_top.sv
// Top level of the DMA region registration table.
// Usage:
//   Input channel in_valid/in_ready carries one transaction: func (0 register,
//   1 unregister, 2 check), address, length and byte_offset. Output channel
//   out_valid/out_ready returns one transaction per input: status and granted.
//   cfg_we/cfg_wdata write align_log2 (reset value 12); write it only when idle.
// Operation:
//   The front end screens arguments in the accept cycle and queues up to two
//   transactions. The back end walks the table one entry a cycle, so a
//   register walks every entry, while unregister and check stop early on a
//   hit; a transaction rejected by screening skips the walk. The back end
//   takes no new item until the last result has been taken.
// Reset:
//   arst_n clears all entry valid bits, the queue and the output register;
//   region bases and lengths are only read behind a valid bit.
// Stall:
//   A held result stops the back end; the queue keeps accepting until full,
//   then in_ready drops.
module dma_region_registration_table_top #(
	parameter int unsigned ENTRIES   = drrt_pkg::ENTRIES_DEF,
	parameter int unsigned ADDR_BITS = drrt_pkg::ADDR_BITS_DEF,
	parameter int unsigned LEN_BITS  = drrt_pkg::LEN_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            func,
	input  logic [ADDR_BITS-1:0]  address,
	input  logic [LEN_BITS-1:0]   length,
	input  logic signed [drrt_pkg::OFS_BITS-1:0] byte_offset,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic                  granted,
	input  logic                  cfg_we,
	input  logic [drrt_pkg::ALIGN_BITS-1:0] cfg_wdata
);
	logic [drrt_pkg::ALIGN_BITS-1:0] align_q;
	logic                 q_valid, q_ready;
	drrt_pkg::op_t        q_op;
	drrt_pkg::status_t    q_status;
	logic [ADDR_BITS-1:0] q_addr;
	logic [LEN_BITS-1:0]  q_len;

	// Alignment register: taken as written, no range clamp.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) align_q <= drrt_pkg::ALIGN_RESET;
		else if (cfg_we) align_q <= cfg_wdata;
	end

	drrt_front #(.ADDR_BITS(ADDR_BITS), .LEN_BITS(LEN_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .func, .address, .length, .byte_offset,
		.align_log2(align_q), .q_valid, .q_ready, .q_op, .q_status, .q_addr, .q_len
	);

	drrt_back #(.ENTRIES(ENTRIES), .ADDR_BITS(ADDR_BITS), .LEN_BITS(LEN_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_op, .q_status, .q_addr, .q_len,
		.out_valid, .out_ready, .status, .granted
	);

	// Grant only ever accompanies an ok status.
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted |-> status == 3'(drrt_pkg::ST_OK))
		else $error("grant with error status");
	// Status stays within the defined codes.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'(drrt_pkg::ST_FULL))
		else $error("undefined status code");
	// A queued transaction is not dropped while the back end is busy.
	a_queue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !q_ready |=> q_valid)
		else $error("queued transaction lost");
endmodule
